// ===== hw/rtl/pltf_pkg.sv =====
// Package for the piecewise-linear table fill unit.
// Holds field widths, reset values and the command/status words between the
// controller and the datapath. No dependencies.
package pltf_pkg;

   // Field widths
   localparam int COORD_W    = 17;   // Q1.16 coordinate
   localparam int SIZE_W     = 7;    // table size register
   localparam int INDEX_W    = 6;    // entry index port
   localparam int DIFF_W     = 18;   // signed coordinate difference
   localparam int MUL_W      = 24;   // size times coordinate
   localparam int DEN_W      = 23;   // size times segment width, magnitude
   localparam int OFF_W      = 25;   // signed entry offset
   localparam int NUM_W      = 43;   // signed interpolation numerator
   localparam int DIVIDEND_W = 42;   // magnitude into the divider
   localparam int DCNT_W     = 6;    // divider iteration count
   localparam int ACC_W      = 44;   // signed running quotient
   localparam int FRAC_W     = 16;

   // Reset values and defaults
   localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 7'd64;
   localparam int DEFAULT_MAX_ENTRIES = 64;
   localparam logic [COORD_W-1:0] VALUE_ONE = 17'h10000;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_first;
      logic latch_cur;
      logic prod1;
      logic offset;
      logic prod2;
      logic sum;
      logic div_start_num;
      logic div_start_step;
      logic latch_num;
      logic latch_step;
      logic advance;
      logic commit;
      logic emit;
   } pltf_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic have_prev;
      logic seg_empty;
      logic div_done;
      logic last_entry;
   } pltf_status_type;

endpackage

// ===== hw/rtl/piecewise_linear_table_fill_unit.sv =====
// Piecewise-linear table fill unit: samples a chain of Q1.16 control points
// into table entries. A point that starts a curve is taken while idle; a
// segment that emits nothing frees the input after PROD1, OFFSET, PROD2 and SUM;
// else the first entry word follows two serial divisions, then one entry word
// per cycle while rsp_ready is high. Synchronous reset clears
// the curve state and sets the table size to 64. Depends on pltf_pkg.
module piecewise_linear_table_fill_unit
   import pltf_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SIZE_W-1:0]  csr_table_size,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [COORD_W-1:0] req_point_x,
   input  logic [COORD_W-1:0] req_point_y,
   input  logic               req_first_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [INDEX_W-1:0] rsp_entry_index,
   output logic [COORD_W-1:0] rsp_entry_value,
   output logic               rsp_last_of_segment
);

   pltf_cmd_type    cmd;
   pltf_status_type status;

   // Configuration is always taken
   assign csr_ready = 1'b1;

   pltf_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_first_point (req_first_point),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .cmd             (cmd)
   );

   pltf_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .csr_write           (csr_valid & csr_ready),
      .csr_table_size      (csr_table_size),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_value     (rsp_entry_value),
      .rsp_last_of_segment (rsp_last_of_segment)
   );

endmodule

// ===== hw/rtl/pltf_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Used by the datapath for the segment start value and per-entry step.
// Depends on pltf_pkg.
module pltf_div
   import pltf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DEN_W-1:0]      divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DEN_W-1:0]      remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DCNT_W-1:0]     count_ff, count_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0]      rem_ff, rem_in;
   logic [DEN_W-1:0]      div_ff, div_in;
   logic [DEN_W:0]        rem_sh;
   logic                  fits;

   // Shift in the next dividend bit and try the subtract
   assign rem_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign fits   = rem_sh >= {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = DCNT_W'(DIVIDEND_W);
         dvd_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? DEN_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DEN_W-1:0];
         dvd_in   = {dvd_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider did not begin after start");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/pltf_datapath.sv =====
// Datapath: curve state, segment setup products, divider and the
// incremental quotient/remainder walk that yields each table entry.
// Depends on pltf_pkg and pltf_div.
module pltf_datapath
   import pltf_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  pltf_cmd_type          cmd,
   output pltf_status_type       status,
   input  logic [COORD_W-1:0]    req_point_x,
   input  logic [COORD_W-1:0]    req_point_y,
   input  logic                  csr_write,
   input  logic [SIZE_W-1:0]     csr_table_size,
   output logic [INDEX_W-1:0]    rsp_entry_index,
   output logic [COORD_W-1:0]    rsp_entry_value,
   output logic                  rsp_last_of_segment
);

   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_ENTRIES);

   // Curve state and configuration
   logic [SIZE_W-1:0]  table_size_ff;
   logic [COORD_W-1:0] prev_x_ff, prev_y_ff;
   logic [SIZE_W-1:0]  fill_start_ff;
   logic               have_prev_ff;

   // Segment setup registers
   logic [COORD_W-1:0]       cur_x_ff, cur_y_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dy_eff_ff;
   logic                     dx_zero_ff;
   logic [DEN_W-1:0]         den_ff;
   logic [MUL_W-1:0]         npx_ff;
   logic [SIZE_W-1:0]        next_ff;
   logic signed [OFF_W-1:0]  off_ff;
   logic [DEN_W+COORD_W-1:0] p1_ff;
   logic signed [NUM_W-1:0]  p2_ff, num_ff;

   // Entry walk registers
   logic [SIZE_W-1:0]        j_ff;
   logic signed [ACC_W-1:0]  q_ff, sq_ff;
   logic [DEN_W-1:0]         r_ff, sr_ff;
   logic                     neg_ff;

   // Combinational values
   logic [SIZE_W-1:0]        n_eff;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dx_abs;
   logic [MUL_W-1:0]         den_prod, npx_prod, nx_prod;
   logic [MUL_W:0]           nx_up;
   logic [MUL_W-FRAC_W:0]    next_raw;
   logic [SIZE_W-1:0]        next_in;
   logic signed [NUM_W-1:0]  step_val, div_src;
   logic [NUM_W-1:0]         div_abs;
   logic                     div_neg;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_quot;
   logic [DEN_W-1:0]         div_rem;
   logic signed [ACC_W-1:0]  q_fix;
   logic [DEN_W-1:0]         r_fix;
   logic [DEN_W:0]           r_sum;
   logic                     r_wrap;

   // Clamp the table size to 1..MAX_ENTRIES
   always_comb begin
      priority if (table_size_ff == '0) n_eff = SIZE_W'(1);
      else if (table_size_ff > MAX_SIZE)  n_eff = MAX_SIZE;
      else                                n_eff = table_size_ff;
   end

   // Differences against the stored point, taken from the incoming word
   assign dx_in = $signed({1'b0, req_point_x}) - $signed({1'b0, prev_x_ff});
   assign dy_in = $signed({1'b0, req_point_y}) - $signed({1'b0, prev_y_ff});

   // First products: denominator, start offset term and fill limit
   assign dx_abs   = dx_ff[DIFF_W-1] ? -dx_ff : dx_ff;
   assign den_prod = MUL_W'(n_eff) * MUL_W'(dx_abs[COORD_W-1:0]);
   assign npx_prod = MUL_W'(n_eff) * MUL_W'(prev_x_ff);
   assign nx_prod  = MUL_W'(n_eff) * MUL_W'(cur_x_ff);
   assign nx_up    = {1'b0, nx_prod} + (MUL_W+1)'(2**FRAC_W - 1);
   assign next_raw = nx_up[MUL_W:FRAC_W];
   assign next_in  = (next_raw > (MUL_W-FRAC_W+1)'(n_eff)) ? n_eff : next_raw[SIZE_W-1:0];

   // Divider operand: numerator or per-entry step, sign split off
   assign step_val = NUM_W'(dy_eff_ff) <<< FRAC_W;
   assign div_src  = cmd.div_start_step ? step_val : num_ff;
   assign div_neg  = div_src[NUM_W-1];
   assign div_abs  = div_neg ? NUM_W'(-div_src) : NUM_W'(div_src);

   pltf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start_num | cmd.div_start_step),
      .dividend  (div_abs[DIVIDEND_W-1:0]),
      .divisor   (den_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Turn the truncating result into a floor quotient with a non-negative remainder
   always_comb begin
      if (neg_ff && div_rem != '0) begin
         q_fix = ~ACC_W'(div_quot);
         r_fix = den_ff - div_rem;
      end else if (neg_ff) begin
         q_fix = -ACC_W'(div_quot);
         r_fix = '0;
      end else begin
         q_fix = ACC_W'(div_quot);
         r_fix = div_rem;
      end
   end

   // Step to the next entry: add the step and carry the remainder over
   assign r_sum  = {1'b0, r_ff} + {1'b0, sr_ff};
   assign r_wrap = r_sum >= {1'b0, den_ff};

   // Curve state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         fill_start_ff <= '0;
         have_prev_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            table_size_ff <= csr_table_size;
         end
         if (cmd.load_first) begin
            prev_x_ff     <= req_point_x;
            prev_y_ff     <= req_point_y;
            fill_start_ff <= '0;
            have_prev_ff  <= 1'b1;
         end else if (cmd.commit) begin
            prev_x_ff     <= cur_x_ff;
            prev_y_ff     <= cur_y_ff;
            fill_start_ff <= next_ff;
         end
      end
   end

   // Segment setup pipeline
   always_ff @(posedge clock) begin
      if (cmd.latch_cur) begin
         cur_x_ff   <= req_point_x;
         cur_y_ff   <= req_point_y;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         dx_zero_ff <= dx_in == '0;
      end
      if (cmd.prod1) begin
         den_ff    <= den_prod[DEN_W-1:0];
         npx_ff    <= npx_prod;
         next_ff   <= next_in;
         dy_eff_ff <= dx_ff[DIFF_W-1] ? -dy_ff : dy_ff;
      end
      if (cmd.offset) begin
         off_ff <= $signed({2'b0, fill_start_ff, FRAC_W'(0)}) - $signed({1'b0, npx_ff});
         j_ff   <= fill_start_ff;
      end else if (cmd.advance) begin
         j_ff   <= j_ff + 1'b1;
      end
      if (cmd.prod2) begin
         p1_ff <= (DEN_W+COORD_W)'(prev_y_ff) * (DEN_W+COORD_W)'(den_ff);
         p2_ff <= NUM_W'(off_ff) * NUM_W'(dy_eff_ff);
      end
      if (cmd.sum) begin
         num_ff <= $signed(NUM_W'(p1_ff)) + p2_ff;
      end
   end

   // Divider bookkeeping and the entry walk
   always_ff @(posedge clock) begin
      if (cmd.div_start_num | cmd.div_start_step) begin
         neg_ff <= div_neg;
      end
      if (cmd.latch_num) begin
         q_ff <= q_fix;
         r_ff <= r_fix;
      end else if (cmd.advance) begin
         q_ff <= q_ff + sq_ff + ACC_W'(r_wrap);
         r_ff <= r_wrap ? DEN_W'(r_sum - {1'b0, den_ff}) : r_sum[DEN_W-1:0];
      end
      if (cmd.latch_step) begin
         sq_ff <= q_fix;
         sr_ff <= r_fix;
      end
   end

   assign status.have_prev  = have_prev_ff;
   assign status.seg_empty  = dx_zero_ff || (fill_start_ff >= next_ff);
   assign status.div_done   = div_done;
   assign status.last_entry = (j_ff + 1'b1) == next_ff;

   // Saturate the running quotient to 0..1.0
   always_comb begin
      priority if (q_ff < 0)                        rsp_entry_value = '0;
      else if (q_ff > $signed(ACC_W'(VALUE_ONE)))   rsp_entry_value = VALUE_ONE;
      else                                          rsp_entry_value = q_ff[COORD_W-1:0];
   end

   assign rsp_entry_index     = j_ff[INDEX_W-1:0];
   assign rsp_last_of_segment = status.last_entry;

   a_index_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> j_ff < next_ff)
      else $error("entry index reached the fill limit");

   a_remainder_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> r_ff < den_ff)
      else $error("running remainder not below denominator");

endmodule

// ===== hw/rtl/pltf_ctrl.sv =====
// Controller: sequences point acceptance, segment setup, the two divisions
// and entry emission. Drives the datapath through pltf_cmd_type.
// Depends on pltf_pkg.
module pltf_ctrl
   import pltf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_first_point,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  pltf_status_type status,
   output pltf_cmd_type    cmd
);

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b00_0000_0001,
      ST_PROD1     = 10'b00_0000_0010,
      ST_OFFSET    = 10'b00_0000_0100,
      ST_PROD2     = 10'b00_0000_1000,
      ST_SUM       = 10'b00_0001_0000,
      ST_LOAD_NUM  = 10'b00_0010_0000,
      ST_WAIT_NUM  = 10'b00_0100_0000,
      ST_LOAD_STEP = 10'b00_1000_0000,
      ST_WAIT_STEP = 10'b01_0000_0000,
      ST_EMIT      = 10'b10_0000_0000
   } pltf_state_type;

   pltf_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_first_point || !status.have_prev) begin
                  cmd.load_first = 1'b1;
               end else begin
                  cmd.latch_cur = 1'b1;
                  state_in      = ST_PROD1;
               end
            end
         end
         ST_PROD1: begin
            cmd.prod1 = 1'b1;
            state_in  = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = ST_PROD2;
         end
         ST_PROD2: begin
            cmd.prod2 = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (status.seg_empty) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_LOAD_NUM;
            end
         end
         ST_LOAD_NUM: begin
            cmd.div_start_num = 1'b1;
            state_in          = ST_WAIT_NUM;
         end
         ST_WAIT_NUM: begin
            if (status.div_done) begin
               cmd.latch_num = 1'b1;
               state_in      = ST_LOAD_STEP;
            end
         end
         ST_LOAD_STEP: begin
            cmd.div_start_step = 1'b1;
            state_in           = ST_WAIT_STEP;
         end
         ST_WAIT_STEP: begin
            if (status.div_done) begin
               cmd.latch_step = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (rsp_ready) begin
               if (status.last_entry) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_EMIT;

   a_emit_needs_curve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status.have_prev)
      else $error("entry word emitted without a started curve");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_table_fill_unit: control points
// go in, predicted table entries are compared word by word as they come out.
// Depends on pltf_pkg and the unit's RTL.
module testbench;
   import pltf_pkg::*;

   localparam longint TIMEOUT_NS = 64'd16_000_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int PHASE_POINTS = 18;
   localparam int FULL_TABLE = 64;

   typedef struct {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               starts_curve;
   } control_point_type;

   typedef struct {
      logic [INDEX_W-1:0] entry_index;
      logic [COORD_W-1:0] entry_value;
      logic               last_of_segment;
   } table_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [SIZE_W-1:0]  csr_table_size = TABLE_SIZE_RESET;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [COORD_W-1:0] req_point_x = '0;
   logic [COORD_W-1:0] req_point_y = '0;
   logic               req_first_point = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [INDEX_W-1:0] rsp_entry_index;
   logic [COORD_W-1:0] rsp_entry_value;
   logic               rsp_last_of_segment;

   control_point_type pending_points[$];
   table_entry_type   table_entries_due[$];
   int                error_count = 0;
   bit                gaps_on = 1'b1;
   bit                pressure_armed = 1'b0;
   logic              hold_off = 1'b0;
   int                send_pause = 0;
   int                take_pause = 0;

   // Curve state of the predictor
   logic [SIZE_W-1:0] table_size_now = TABLE_SIZE_RESET;
   longint            curve_prev_x = 0;
   longint            curve_prev_y = 0;
   longint            fill_from = 0;
   bit                curve_open = 1'b0;

   piecewise_linear_table_fill_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_table_size      (csr_table_size),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_first_point     (req_first_point),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_value     (rsp_entry_value),
      .rsp_last_of_segment (rsp_last_of_segment)
   );

   always #4 clock = ~clock;

   // Exact rational interpolation, floored, then clipped to 0..1.0
   function automatic logic [COORD_W-1:0] interpolate(longint j, longint n, longint x,
                                                      longint y);
      longint dx, dy, offset, span, num, q;
      dx = x - curve_prev_x;
      dy = y - curve_prev_y;
      offset = j * 65536 - n * curve_prev_x;
      span = n * dx;
      num = curve_prev_y * span + offset * dy;
      if (span < 0) begin
         span = -span;
         num = -num;
      end
      if (span == 0 || num < 0) return '0;
      q = num / span;
      if (q > 65536) q = 65536;
      return q[COORD_W-1:0];
   endfunction

   // Advance the curve by one point and queue the entries it closes
   function automatic void fill_segment(control_point_type p);
      longint n, x, y, upto, j;
      table_entry_type e;
      n = table_size_now;
      if (n < 1) n = 1;
      if (n > FULL_TABLE) n = FULL_TABLE;
      x = p.point_x;
      y = p.point_y;
      if (p.starts_curve || !curve_open) begin
         curve_prev_x = x;
         curve_prev_y = y;
         fill_from = 0;
         curve_open = 1'b1;
         return;
      end
      upto = (n * x + 65535) >> 16;
      if (upto > n) upto = n;
      if (x != curve_prev_x) begin
         for (j = fill_from; j < upto; j++) begin
            e.entry_index = j[INDEX_W-1:0];
            e.entry_value = interpolate(j, n, x, y);
            e.last_of_segment = (j + 1 == upto);
            table_entries_due.push_back(e);
         end
      end
      curve_prev_x = x;
      curve_prev_y = y;
      fill_from = upto;
   endfunction

   // Mostly no pause, some short ones, a few long ones
   function automatic int pick_pause();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void add_point(int x, int y, bit starts_curve);
      control_point_type p;
      p.point_x = x[COORD_W-1:0];
      p.point_y = y[COORD_W-1:0];
      p.starts_curve = starts_curve;
      pending_points.push_back(p);
   endfunction

   function automatic int random_y();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 17'h1FFFF);
      return $urandom_range(0, 65536);
   endfunction

   // Mostly rising curves with random content, the rest loose points
   function automatic void add_random_points(int count);
      int made, pts, k, x, step;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 3) != 0) begin
            pts = $urandom_range(2, 6);
            x = $urandom_range(0, 1) ? 0 : $urandom_range(0, 16384);
            add_point(x, random_y(), 1'b1);
            for (k = 1; k < pts; k++) begin
               step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24000);
               if (k == pts - 1 && $urandom_range(0, 1)) x = 65536;
               else if (x + step > 65536) x = 65536;
               else x = x + step;
               add_point(x, random_y(), 1'b0);
            end
            made += pts;
         end else begin
            add_point($urandom_range(0, 17'h1FFFF), $urandom_range(0, 17'h1FFFF),
                      1'($urandom_range(0, 1)));
            made++;
         end
      end
   endfunction

   task automatic write_table_size(logic [SIZE_W-1:0] size);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_table_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      table_size_now = size;
   endtask

   // Hold until every point is taken and every entry has come back
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_points.size() != 0 || req_valid || table_entries_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Point driver: offer the next pending word, pausing between words
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_pause <= 0;
      end else begin
         if (req_valid && req_ready) begin
            fill_segment('{req_point_x, req_point_y, req_first_point});
         end
         if (!req_valid || req_ready) begin
            if (send_pause > 0) begin
               send_pause <= send_pause - 1;
               req_valid <= 1'b0;
            end else if (pending_points.size() != 0) begin
               control_point_type p;
               p = pending_points.pop_front();
               req_point_x <= p.point_x;
               req_point_y <= p.point_y;
               req_first_point <= p.starts_curve;
               req_valid <= 1'b1;
               send_pause <= pick_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Entry monitor: compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_pause <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (table_entries_due.size() == 0) begin
               $error("unexpected entry word: index %0d value %0d",
                      rsp_entry_index, rsp_entry_value);
               error_count++;
            end else begin
               table_entry_type e;
               e = table_entries_due.pop_front();
               if (rsp_entry_index !== e.entry_index) begin
                  $error("entry_index: expected %0d, got %0d", e.entry_index, rsp_entry_index);
                  error_count++;
               end
               if (rsp_entry_value !== e.entry_value) begin
                  $error("entry_value: expected %0d, got %0d", e.entry_value, rsp_entry_value);
                  error_count++;
               end
               if (rsp_last_of_segment !== e.last_of_segment) begin
                  $error("last_of_segment: expected %0d, got %0d",
                         e.last_of_segment, rsp_last_of_segment);
                  error_count++;
               end
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (take_pause > 0) begin
            take_pause <= take_pause - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            take_pause <= pick_pause();
         end
      end
   end

   // Long receiver hold-off so the unit backs up into its input
   initial begin
      wait (pressure_armed);
      repeat (40) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Stimulus: directed curves at the reset size, then random phases
   initial begin
      logic [SIZE_W-1:0] phase_size[8];
      int phase;
      phase_size = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd0, 7'd64, 7'd0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A point with no open curve, then a full rising line
      add_point(0, 0, 1'b0);
      add_point(65536, 65536, 1'b0);
      // Falling half, zero-width step, then rise to the end
      add_point(0, 65536, 1'b1);
      add_point(32768, 0, 1'b0);
      add_point(32768, 12345, 1'b0);
      add_point(65536, 65536, 1'b0);
      // All ones start, backward to zero, then beyond 1.0
      add_point(17'h1FFFF, 17'h1FFFF, 1'b1);
      add_point(0, 0, 1'b0);
      add_point(17'h1FFFF, 17'h1FFFF, 1'b0);
      // Steep slope that saturates at 1.0
      add_point(0, 0, 1'b1);
      add_point(65536, 17'h1FFFF, 1'b0);
      // Backward segment from an unfilled table
      add_point(40000, 0, 1'b1);
      add_point(20000, 65536, 1'b0);
      // Fill start above next: nothing, then resume low
      add_point(0, 0, 1'b1);
      add_point(65536, 30000, 1'b0);
      add_point(1000, 50000, 1'b0);
      add_point(65536, 0, 1'b0);
      // Entries left of the start point clip to zero
      add_point(30000, 0, 1'b1);
      add_point(65536, 65536, 1'b0);
      // Tiny first segment
      add_point(0, 12345, 1'b1);
      add_point(1, 54321, 1'b0);
      wait_until_drained();

      for (phase = 0; phase < 8; phase++) begin
         if (phase_size[phase] == 7'd0 && phase != 1) begin
            write_table_size(SIZE_W'($urandom_range(3, 63)));
         end else begin
            write_table_size(phase_size[phase]);
         end
         @(negedge clock);
         gaps_on = (phase % 2 == 0);
         if (phase == 3) begin
            gaps_on = 1'b0;
            pressure_armed = 1'b1;
         end
         add_random_points(PHASE_POINTS);
         wait_until_drained();
      end

      if (error_count == 0 && table_entries_due.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("testbench: errors");
      $finish;
   end

endmodule

// ===== piecewise_linear_table_fill_unit.f =====
hw/rtl/pltf_pkg.sv
hw/rtl/pltf_div.sv
hw/rtl/pltf_datapath.sv
hw/rtl/pltf_ctrl.sv
hw/rtl/piecewise_linear_table_fill_unit.sv
sim/testbench.sv
